[rtl/core/ifbl_pkg.sv]
// Package with the transfer types and operation and status codes of the FIFO bank.
`timescale 1ns / 1ps
`default_nettype none

package ifbl_pkg;

	// Operation codes carried in the request; the fourth code is unused.
	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	// Status codes returned with every response.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADIDX = 2'd3
	} status_t;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned OCC_W   = 5;
	localparam int unsigned INDEX_W = 3;

	// One request transfer.
	typedef struct packed {
		logic [1:0]                op;
		logic [INDEX_W-1:0]        fifo_index;
		logic signed [WORD_W-1:0]  write_data;
	} req_t;

	// One response transfer.
	typedef struct packed {
		logic signed [WORD_W-1:0]  read_data;
		status_t                   status;
		logic [OCC_W-1:0]          occupancy;
		logic [WORD_W-1:0]         lost_total;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/core/indexed_fifo_bank_with_loss_count.sv]
// Top level of the indexed FIFO bank with per-FIFO saturating loss counters.
`timescale 1ns / 1ps
`default_nettype none

// A bank of QUEUE_COUNT ring-buffer FIFOs, each QUEUE_DEPTH signed 32-bit
// words deep, sharing one word store. Every request names a FIFO and asks
// for init, read or write, and produces exactly one response, in order.
// A request is taken every cycle while the response path keeps moving: the
// pointers, counts and loss counters are updated in the cycle of the transfer,
// the word store is read through its registered port, and the response is
// held first in stage one, beside the read register, and then in the output
// register. A read of an empty FIFO returns empty status rather than waiting;
// a write to a full FIFO is dropped and counted.
module indexed_fifo_bank_with_loss_count
	import ifbl_pkg::*;
#(
	parameter int unsigned QUEUE_COUNT = 4,
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int unsigned ENTRIES = QUEUE_COUNT * QUEUE_DEPTH;
	localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned Q_W     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int unsigned ADDR_W  = $clog2(ENTRIES);

	// Per-FIFO control state.
	logic [PTR_W-1:0]  rd_ptr_q [QUEUE_COUNT];
	logic [PTR_W-1:0]  wr_ptr_q [QUEUE_COUNT];
	logic [CNT_W-1:0]  cnt_q    [QUEUE_COUNT];
	logic [WORD_W-1:0] lost_q   [QUEUE_COUNT];

	// Stage one: metadata of the request whose store read is in flight.
	logic              v_s1;
	status_t           status_s1;
	logic [OCC_W-1:0]  occ_s1;
	logic [WORD_W-1:0] lost_s1;
	logic              pop_s1;

	// Output register.
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              req_fire;
	logic              s1_move;
	logic              bad_idx;
	logic [Q_W-1:0]    q;
	logic [PTR_W-1:0]  cur_rd;
	logic [PTR_W-1:0]  cur_wr;
	logic [CNT_W-1:0]  cur_cnt;
	logic [WORD_W-1:0] cur_lost;
	logic [PTR_W-1:0]  nxt_rd;
	logic [PTR_W-1:0]  nxt_wr;
	logic [CNT_W-1:0]  nxt_cnt;
	logic [WORD_W-1:0] nxt_lost;
	status_t           nxt_status;
	logic              do_pop;
	logic              do_push;
	logic [ADDR_W-1:0] base_addr;
	logic [WORD_W-1:0] store_rdata;

	// Handshake: stage one advances into the output register whenever it is free or being emptied.
	assign s1_move   = v_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !v_s1 || s1_move;
	assign req_fire  = req_valid && req_ready;

	// Select the addressed FIFO's state.
	assign bad_idx  = ({1'b0, req.fifo_index} >= (INDEX_W + 1)'(QUEUE_COUNT));
	assign q        = Q_W'(req.fifo_index);
	assign cur_rd   = rd_ptr_q[q];
	assign cur_wr   = wr_ptr_q[q];
	assign cur_cnt  = cnt_q[q];
	assign cur_lost = lost_q[q];

	// Work out the operation and the FIFO's next state.
	always_comb begin
		nxt_rd     = cur_rd;
		nxt_wr     = cur_wr;
		nxt_cnt    = cur_cnt;
		nxt_lost   = cur_lost;
		nxt_status = ST_OK;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		case (req.op)
			OP_INIT: begin
				nxt_rd   = '0;
				nxt_wr   = '0;
				nxt_cnt  = '0;
				nxt_lost = '0;
			end
			OP_READ: begin
				if (cur_cnt == '0) begin
					nxt_status = ST_EMPTY;
				end else begin
					do_pop  = 1'b1;
					nxt_rd  = (cur_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_rd + 1'b1;
					nxt_cnt = cur_cnt - 1'b1;
				end
			end
			OP_WRITE: begin
				if (cur_cnt == CNT_W'(QUEUE_DEPTH)) begin
					nxt_status = ST_FULL;
					if (cur_lost != '1) begin
						nxt_lost = cur_lost + 1'b1;
					end
				end else begin
					do_push = 1'b1;
					nxt_wr  = (cur_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_wr + 1'b1;
					nxt_cnt = cur_cnt + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (bad_idx) begin
			nxt_status = ST_BADIDX;
			do_pop     = 1'b0;
			do_push    = 1'b0;
		end
	end

	// Per-FIFO state registers, updated on a request transfer with a valid FIFO index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				cnt_q[i]    <= '0;
				lost_q[i]   <= '0;
			end
		end else if (req_fire && !bad_idx) begin
			rd_ptr_q[q] <= nxt_rd;
			wr_ptr_q[q] <= nxt_wr;
			cnt_q[q]    <= nxt_cnt;
			lost_q[q]   <= nxt_lost;
		end
	end

	// Shared word store, addressed by FIFO base plus slot pointer.
	assign base_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH);

	ifbl_word_store #(
		.ENTRIES (ENTRIES),
		.ADDR_W  (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (req_fire && do_push),
		.waddr (base_addr + ADDR_W'(cur_wr)),
		.wdata (req.write_data),
		.re    (req_fire && do_pop),
		.raddr (base_addr + ADDR_W'(cur_rd)),
		.rdata (store_rdata)
	);

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage one metadata.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			status_s1 <= nxt_status;
			pop_s1    <= do_pop;
			occ_s1    <= bad_idx ? '0 : OCC_W'(nxt_cnt);
			lost_s1   <= bad_idx ? '0 : nxt_lost;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output payload; only a successful read returns a word.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			rsp_q.read_data  <= pop_s1 ? store_rdata : '0;
			rsp_q.status     <= status_s1;
			rsp_q.occupancy  <= occ_s1;
			rsp_q.lost_total <= lost_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/core/ifbl_word_store.sv]
// Shared word store of the FIFO bank: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ifbl_word_store
	import ifbl_pkg::*;
#(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned ADDR_W  = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data register holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
